// ===== hw/rtl/box_blur_5x5_stream_core_defines.svh =====
// Assertion macros shared by the box blur RTL.
`ifndef BOX_BLUR_5X5_STREAM_CORE_DEFINES_SVH
`define BOX_BLUR_5X5_STREAM_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BB5_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BB5_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/bb5_pkg.sv =====
// Constants and register codes for the 5x5 box blur stream core.
package bb5_pkg;

   // Pixel and coordinate widths.
   localparam int PIX_W = 8;
   localparam int COORD_W = 12;
   localparam int SIZE_W = 13;

   // Window geometry: five pixels per side, four rows of history.
   localparam int WIN = 5;
   localparam int HIST = WIN - 1;
   localparam int PAD = WIN / 2;

   // Line store: one word of four history pixels per column.
   localparam int LB_DEPTH = 4096;
   localparam int LB_W = HIST * PIX_W;

   // Sums: one column of five pixels, then five columns.
   localparam int COLSUM_W = 11;
   localparam int SUM_W = 13;

   // Division by 25 as a multiply by ceil(2^17 / 25) and a shift; exact for sums up to 6375.
   localparam logic [SUM_W-1:0] DIV_MULT = 13'd5243;
   localparam int DIV_SHIFT = 17;
   localparam logic [SUM_W-1:0] SUM_MAX = 13'd6375;

   // Legal frame size limits; register values outside are saturated.
   localparam logic [SIZE_W-1:0] SIZE_MIN = 13'd5;
   localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;
   localparam logic [SIZE_W-1:0] WIDTH_RESET = 13'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

   // Configuration register indexes.
   localparam logic CSR_FRAME_WIDTH = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

endpackage

// ===== hw/rtl/box_blur_5x5_stream_core.sv =====
// Streaming 5x5 box blur core with line store, column sums and output register.
// Accepts one raster-order pixel per clock and returns the truncated mean of the
// 5x5 window for every pixel whose window lies inside the frame, tagged with the
// window center coordinates and an end-of-frame mark on the bottom-right result.
// Throughput is one pixel per cycle; the pipeline stalls only while the output
// register holds a result that rsp_ready has not taken. From the input transaction
// to its result the registered steps are the line store read, column sum, window
// sum, and the divide-by-25 multiply into the output register. The line store is
// a single 4096 x 32 memory, read once and written once per pixel, so no clearing
// pass is needed after reset. The user must write frame sizes through the csr_
// port only while the core is idle (not enforced); they are saturated to 5..4096.
`include "box_blur_5x5_stream_core_defines.svh"

module box_blur_5x5_stream_core (
   input  logic                          clock,
   input  logic                          reset,
   // Pixel input channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bb5_pkg::PIX_W-1:0]     req_pixel_value,
   // Result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bb5_pkg::PIX_W-1:0]     rsp_blurred_value,
   output logic [bb5_pkg::COORD_W-1:0]   rsp_out_row,
   output logic [bb5_pkg::COORD_W-1:0]   rsp_out_col,
   output logic                          rsp_frame_end,
   // Configuration write port
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [bb5_pkg::SIZE_W-1:0]    csr_wr_data
);

   // Configuration registers.
   logic [bb5_pkg::SIZE_W-1:0] frame_width_ff;
   logic [bb5_pkg::SIZE_W-1:0] frame_height_ff;
   logic [bb5_pkg::SIZE_W-1:0] eff_w;
   logic [bb5_pkg::SIZE_W-1:0] eff_h;

   // Position counters.
   logic [bb5_pkg::COORD_W-1:0] col_ff, col_in;
   logic [bb5_pkg::COORD_W-1:0] row_ff, row_in;
   logic                        col_wrap;
   logic [bb5_pkg::SIZE_W-1:0]  row_pre;
   logic [bb5_pkg::COORD_W-1:0] row_cur;
   logic [bb5_pkg::COORD_W-1:0] col_cur;
   logic [bb5_pkg::SIZE_W-1:0]  col_next;
   logic [bb5_pkg::SIZE_W-1:0]  row_next;
   logic                        cur_emit;
   logic                        cur_end;

   // Pipeline control.
   logic pipe_en;
   logic req_accept;

   // Stage A: accepted pixel and line store read data.
   logic                        a_vld_ff;
   logic [bb5_pkg::PIX_W-1:0]   a_px_ff;
   logic [bb5_pkg::COORD_W-1:0] a_col_ff;
   logic [bb5_pkg::COORD_W-1:0] a_row_ff;
   logic                        a_emit_ff;
   logic                        a_end_ff;
   logic [bb5_pkg::LB_W-1:0]    lb_rd_ff;
   logic [bb5_pkg::LB_W-1:0]    line_mem [bb5_pkg::LB_DEPTH];

   // Column sums of the current window, oldest column first.
   logic [bb5_pkg::COLSUM_W-1:0] colsum_ff [bb5_pkg::WIN];
   logic [bb5_pkg::COLSUM_W-1:0] new_colsum;

   // Stage B: result tag for the column just shifted in.
   logic                        b_vld_ff;
   logic [bb5_pkg::COORD_W-1:0] b_row_ff;
   logic [bb5_pkg::COORD_W-1:0] b_col_ff;
   logic                        b_end_ff;

   // Stage C: window sum.
   logic                        c_vld_ff;
   logic [bb5_pkg::SUM_W-1:0]   c_sum_ff;
   logic [bb5_pkg::COORD_W-1:0] c_row_ff;
   logic [bb5_pkg::COORD_W-1:0] c_col_ff;
   logic                        c_end_ff;
   logic [bb5_pkg::SUM_W-1:0]   win_sum;
   logic [2*bb5_pkg::SUM_W-1:0] div_prod;

   // Output register.
   logic                        rsp_valid_ff;
   logic [bb5_pkg::PIX_W-1:0]   rsp_value_ff;
   logic [bb5_pkg::COORD_W-1:0] rsp_row_ff;
   logic [bb5_pkg::COORD_W-1:0] rsp_col_ff;
   logic                        rsp_end_ff;

   // The whole pipeline advances unless a finished result is waiting.
   assign pipe_en    = !rsp_valid_ff || rsp_ready;
   assign req_ready  = pipe_en;
   assign req_accept = req_valid && pipe_en;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= bb5_pkg::WIDTH_RESET;
         frame_height_ff <= bb5_pkg::HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            bb5_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wr_data;
            bb5_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Saturate the frame size into the supported range.
   always_comb begin
      if (frame_width_ff < bb5_pkg::SIZE_MIN) begin
         eff_w = bb5_pkg::SIZE_MIN;
      end else if (frame_width_ff > bb5_pkg::SIZE_MAX) begin
         eff_w = bb5_pkg::SIZE_MAX;
      end else begin
         eff_w = frame_width_ff;
      end
      if (frame_height_ff < bb5_pkg::SIZE_MIN) begin
         eff_h = bb5_pkg::SIZE_MIN;
      end else if (frame_height_ff > bb5_pkg::SIZE_MAX) begin
         eff_h = bb5_pkg::SIZE_MAX;
      end else begin
         eff_h = frame_height_ff;
      end
   end

   // Position of the incoming pixel and of the one after it.
   always_comb begin
      col_wrap = {1'b0, col_ff} >= eff_w;
      row_pre  = col_wrap ? ({1'b0, row_ff} + 13'd1) : {1'b0, row_ff};
      row_cur  = (row_pre >= eff_h) ? '0 : row_pre[bb5_pkg::COORD_W-1:0];
      col_cur  = col_wrap ? '0 : col_ff;
      col_next = {1'b0, col_cur} + 13'd1;
      row_next = {1'b0, row_cur} + 13'd1;
      if (col_next >= eff_w) begin
         col_in = '0;
         row_in = (row_next >= eff_h) ? '0 : row_next[bb5_pkg::COORD_W-1:0];
      end else begin
         col_in = col_next[bb5_pkg::COORD_W-1:0];
         row_in = row_cur;
      end
      cur_emit = (row_cur >= bb5_pkg::COORD_W'(bb5_pkg::HIST))
              && (col_cur >= bb5_pkg::COORD_W'(bb5_pkg::HIST));
      cur_end  = ({1'b0, row_cur} == (eff_h - 13'd1))
              && ({1'b0, col_cur} == (eff_w - 13'd1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage A registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         a_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_px_ff   <= req_pixel_value;
         a_col_ff  <= col_cur;
         a_row_ff  <= row_cur;
         a_emit_ff <= cur_emit;
         a_end_ff  <= cur_end;
      end
   end

   // Line store: read the history of the incoming column, age it one stage later.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         lb_rd_ff <= line_mem[col_cur];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en && a_vld_ff) begin
         line_mem[a_col_ff] <= {lb_rd_ff[bb5_pkg::LB_W-bb5_pkg::PIX_W-1:0], a_px_ff};
      end
   end

   // Sum of the new column: four history rows and the current pixel.
   assign new_colsum = bb5_pkg::COLSUM_W'(lb_rd_ff[31:24])
                     + bb5_pkg::COLSUM_W'(lb_rd_ff[23:16])
                     + bb5_pkg::COLSUM_W'(lb_rd_ff[15:8])
                     + bb5_pkg::COLSUM_W'(lb_rd_ff[7:0])
                     + bb5_pkg::COLSUM_W'(a_px_ff);

   // Slide the window one column to the right.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bb5_pkg::WIN; i++) begin
            colsum_ff[i] <= '0;
         end
      end else if (pipe_en && a_vld_ff) begin
         for (int i = 0; i < bb5_pkg::WIN - 1; i++) begin
            colsum_ff[i] <= colsum_ff[i+1];
         end
         colsum_ff[bb5_pkg::WIN-1] <= new_colsum;
      end
   end

   // Stage B tag.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         b_vld_ff <= a_vld_ff && a_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         b_row_ff <= a_row_ff - bb5_pkg::COORD_W'(bb5_pkg::PAD);
         b_col_ff <= a_col_ff - bb5_pkg::COORD_W'(bb5_pkg::PAD);
         b_end_ff <= a_end_ff;
      end
   end

   // Stage C: add the five column sums.
   assign win_sum = bb5_pkg::SUM_W'(colsum_ff[0]) + bb5_pkg::SUM_W'(colsum_ff[1])
                  + bb5_pkg::SUM_W'(colsum_ff[2]) + bb5_pkg::SUM_W'(colsum_ff[3])
                  + bb5_pkg::SUM_W'(colsum_ff[4]);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         c_sum_ff <= win_sum;
         c_row_ff <= b_row_ff;
         c_col_ff <= b_col_ff;
         c_end_ff <= b_end_ff;
      end
   end

   // Divide by 25 through the reciprocal multiply.
   assign div_prod = (2*bb5_pkg::SUM_W)'(c_sum_ff) * (2*bb5_pkg::SUM_W)'(bb5_pkg::DIV_MULT);

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_value_ff <= div_prod[bb5_pkg::DIV_SHIFT +: bb5_pkg::PIX_W];
         rsp_row_ff   <= c_row_ff;
         rsp_col_ff   <= c_col_ff;
         rsp_end_ff   <= c_end_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_blurred_value = rsp_value_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_frame_end     = rsp_end_ff;

   // Checks on the pipeline.
   `BB5_ASSERT_NEXT(a_load_chk, clock, reset, req_valid && req_ready, a_vld_ff, "accepted transaction did not reach stage A")
   `BB5_ASSERT_NOW(a_emit_chk, clock, reset, a_vld_ff && a_emit_ff, (a_row_ff >= 12'd4) && (a_col_ff >= 12'd4), "result marked for a border pixel")
   `BB5_ASSERT_NEXT(stall_chk, clock, reset, !pipe_en, $stable(c_vld_ff) && $stable(b_vld_ff), "pipeline moved during a stall")
   `BB5_ASSERT_NOW(sum_chk, clock, reset, c_vld_ff, c_sum_ff <= bb5_pkg::SUM_MAX, "window sum above 25 full-scale pixels")

endmodule
